### sv/adq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adq_pkg: shared types and constants of the array double-ended queue
// Field widths, mode and status codes, and the controller command bundle.
// ----------------------------------------------------------------------------
package adq_pkg;

  localparam int MODE_W   = 3;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int CAP_W    = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_REAR  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_REAR   = 3'd3,
    MODE_PEEK_FRONT = 3'd4,
    MODE_PEEK_REAR  = 3'd5
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE    = 2'd0,
    STATUS_REFUSED = 2'd1,
    STATUS_EMPTY   = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture item, start slot read
    logic exec;  // apply operation, load result registers
  } adq_cmd_t;

endpackage : adq_pkg
`default_nettype wire

### sv/adq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adq_ctrl: sequencing state machine of the double-ended queue
// Takes one item, runs it through the datapath, and holds the result until
// the downstream side takes it.
// ----------------------------------------------------------------------------
module adq_ctrl
  import adq_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     out_stall_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  output adq_cmd_t      cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.load = 1'b0;
    cmd_o.exec = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

endmodule : adq_ctrl
`default_nettype wire

### sv/adq_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adq_datapath: slot memory, indices and result registers
// Holds the linear slot array, head and tail indices, the empty flag and the
// capacity register, and works out each operation's result.
// ----------------------------------------------------------------------------
module adq_datapath
  import adq_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire adq_cmd_t            cmd_i,
  input  wire logic                cfg_we_i,
  input  wire logic [CAP_W-1:0]    cfg_wdata_i,
  input  wire logic [MODE_W-1:0]   mode_i,
  input  wire logic [DATA_W-1:0]   data_in_i,
  output logic [DATA_W-1:0]        data_out_o,
  output logic [STATUS_W-1:0]      status_o,
  output logic                     empty_now_o,
  output logic                     full_now_o
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = (IW + 1 > CAP_W) ? IW + 1 : CAP_W;

  logic [DATA_W-1:0] mem [DEPTH];

  logic [CAP_W-1:0]  cap_q;
  logic [IW-1:0]     head_q, head_d;
  logic [IW-1:0]     tail_q, tail_d;
  logic              empty_q, empty_d;
  mode_e             mode_q;
  logic [DATA_W-1:0] din_q;
  logic [DATA_W-1:0] rdata_q;

  logic [IW-1:0]     raddr;
  logic [IW-1:0]     waddr;
  logic              wen;
  logic [CW-1:0]     eff_cap;
  logic              full_cur;
  logic [DATA_W-1:0] dout;
  status_e           status;

  function automatic logic is_full(logic [CW-1:0] cap, logic emp, logic [IW-1:0] tail);
    logic res;
    if (cap == '0)    res = 1'b1;
    else if (emp)     res = 1'b0;
    else              res = ((CW'(tail) + CW'(1)) >= cap);
    return res;
  endfunction

  assign eff_cap = (CW'(cap_q) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(cap_q);
  assign full_cur = is_full(eff_cap, empty_q, tail_q);

  // Front modes read at the head, everything else at the tail.
  assign raddr = (mode_i == MODE_POP_FRONT || mode_i == MODE_PEEK_FRONT) ? head_q : tail_q;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    empty_d = empty_q;
    wen     = 1'b0;
    waddr   = '0;
    dout    = '0;
    status  = STATUS_DONE;
    unique case (mode_q)
      MODE_PUSH_FRONT: begin
        if (full_cur || (!empty_q && head_q == '0)) begin
          status = STATUS_REFUSED;
        end else begin
          wen = 1'b1;
          if (empty_q) begin
            head_d  = '0;
            tail_d  = '0;
            empty_d = 1'b0;
          end else begin
            head_d = head_q - IW'(1);
            waddr  = head_q - IW'(1);
          end
        end
      end
      MODE_PUSH_REAR: begin
        if (full_cur) begin
          status = STATUS_REFUSED;
        end else begin
          wen = 1'b1;
          if (empty_q) begin
            head_d  = '0;
            tail_d  = '0;
            empty_d = 1'b0;
          end else begin
            tail_d = tail_q + IW'(1);
            waddr  = tail_q + IW'(1);
          end
        end
      end
      MODE_POP_FRONT, MODE_POP_REAR: begin
        if (empty_q) begin
          status = STATUS_EMPTY;
        end else begin
          dout = rdata_q;
          // Last entry gone: restart both indices at slot zero.
          if (head_q == tail_q) begin
            head_d  = '0;
            tail_d  = '0;
            empty_d = 1'b1;
          end else if (mode_q == MODE_POP_FRONT) begin
            head_d = head_q + IW'(1);
          end else begin
            tail_d = tail_q - IW'(1);
          end
        end
      end
      MODE_PEEK_FRONT, MODE_PEEK_REAR: begin
        if (empty_q) status = STATUS_EMPTY;
        else         dout   = rdata_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rdata_q <= mem[raddr];
    end
    if (cmd_i.exec && wen) begin
      mem[waddr] <= din_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_e'(mode_i);
      din_q  <= data_in_i;
    end
    if (cmd_i.exec) begin
      data_out_o  <= dout;
      status_o    <= status;
      empty_now_o <= empty_d;
      full_now_o  <= is_full(eff_cap, empty_d, tail_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CAP_RESET;
      head_q  <= '0;
      tail_q  <= '0;
      empty_q <= 1'b1;
    end else begin
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      if (cmd_i.exec) begin
        head_q  <= head_d;
        tail_q  <= tail_d;
        empty_q <= empty_d;
      end
    end
  end

endmodule : adq_datapath
`default_nettype wire

### sv/array_double_ended_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// array_double_ended_queue: double-ended queue in a linear slot array
// Push, pop and peek at either end; one result per item with data, status
// and empty/full flags.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------
//  input    | in_valid_i / in_stall_o   | mode_i, data_in_i
//  output   | out_valid_o / out_stall_i | data_out_o, status_o, empty_now_o,
//           |                           | full_now_o
//  config   | cfg_we_i                  | cfg_wdata_i (capacity)
//
//  Each item runs in order: the accepting edge starts the registered slot
//  memory read, the EXEC state applies the operation and loads the result
//  registers, and the OUT state then offers the result until it is taken.
//  The next item is accepted in the cycle after the result is taken.
//  A stalled result holds in the output register and blocks new items.
//  Reset clears the indices, marks the queue empty and sets capacity to 64;
//  slot contents are not cleared.
// ----------------------------------------------------------------------------
module array_double_ended_queue
  import adq_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [CAP_W-1:0]           cfg_wdata_i,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [MODE_W-1:0]          mode_i,
  input  wire logic signed [DATA_W-1:0]   data_in_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic signed [DATA_W-1:0]        data_out_o,
  output logic [STATUS_W-1:0]             status_o,
  output logic                            empty_now_o,
  output logic                            full_now_o
);

  adq_cmd_t          cmd;
  logic [DATA_W-1:0] dout;

  adq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  adq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mode_i      (mode_i),
    .data_in_i   (data_in_i),
    .data_out_o  (dout),
    .status_o    (status_o),
    .empty_now_o (empty_now_o),
    .full_now_o  (full_now_o)
  );

  assign data_out_o = $signed(dout);

endmodule : array_double_ended_queue
`default_nettype wire

### sv/adq_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adq_checker: port-level checks of the double-ended queue
// Watches the top-level ports and flags results that break the queue rules.
// ----------------------------------------------------------------------------
module adq_checker
  import adq_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_stall_o,
  input  wire logic                       out_valid_o,
  input  wire logic                       out_stall_i,
  input  wire logic signed [DATA_W-1:0]   data_out_o,
  input  wire logic [STATUS_W-1:0]        status_o,
  input  wire logic                       empty_now_o
);

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(data_out_o)
      && $stable(status_o))
    else $error("stalled result changed");

  // No new item while a result is pending.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input accepted while result pending");

  // Underflow leaves the queue empty and returns no data.
  a_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_EMPTY |-> empty_now_o && data_out_o == '0)
    else $error("underflow result inconsistent");

  // A refused push returns no data.
  a_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_REFUSED |-> data_out_o == '0)
    else $error("refused push returned data");

endmodule : adq_checker

bind array_double_ended_queue adq_checker u_adq_checker (.*);
`default_nettype wire
